FILE: hw/rtl/scfb_pkg.sv
package scfb_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0]  PREFIX_A    = 8'hEB;
   localparam logic [7:0]  PREFIX_B    = 8'h90;
   localparam logic [7:0]  END_FLAG    = 8'h7E;
   localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
   localparam logic [15:0] XMODEM_INIT = 16'h0000;
   localparam logic [15:0] MODBUS_POLY = 16'hA001;
   localparam logic [15:0] XMODEM_POLY = 16'h1021;

   localparam logic MODE_MODBUS = 1'b0;
   localparam logic MODE_FRAMED = 1'b1;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   // register index of frame_mode
   localparam logic REG_FRAME_MODE = 1'b0;

   typedef struct packed {
      logic wr;
      logic mode;
   } cfg_type;

   // one classified payload byte, handed from front to back
   typedef struct packed {
      logic        mode;
      logic        second;
      logic        err;
      logic        last;
      logic [7:0]  data;
      logic [7:0]  held;
      logic [15:0] crc;
   } entry_type;

   function automatic logic [15:0] modbus_update(input logic [15:0] crc_i,
                                                 input logic [7:0]  b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ MODBUS_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [15:0] xmodem_update(input logic [15:0] crc_i,
                                                 input logic [7:0]  b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = (c << 1) ^ XMODEM_POLY;
         else       c = c << 1;
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/serial_frame_crc_builder.sv
// serial frame builder with crc-16 trailer
// req channel: one payload byte per transaction, tlast on the final byte of a frame.
// rsp channel: frame bytes in transmit order, tlast on the final byte of a frame,
// tuser set on the single error transaction given for a framed payload under two bytes.
// csr port: frame_mode at address 0; 0 appends crc-16/modbus (low byte first),
// 1 sends eb 90 eb 90 eb 90, payload, crc-16/xmodem (high byte first) and 7e.
// write frame_mode only while the block is idle.
// the front computes the byte-wide crc step combinationally and can take one byte
// per cycle while the queue is not full; it writes a classified entry into a
// QUEUE_DEPTH-deep queue. the back expands each entry into 1 to 11 output bytes,
// one per cycle through an output register while rsp_tready stays high.
// an accepted byte is first written into the queue and then loaded into the
// output register, from which it is presented on rsp.
// a framed first byte is held and produces output only with the second byte.
// while the back sends prefix or trailer bursts the queue fills and req_tready
// drops; a stalled rsp_tready holds the output register and backs up the queue.
// reset empties the queue and the output register and selects mode 0.
module serial_frame_crc_builder #(
   parameter int unsigned QUEUE_DEPTH = scfb_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] payload_byte
   input  logic        req_tlast,    // payload_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // out_last
   output logic        rsp_tuser,    // [0] frame_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic mode_ff, mode_in;
   logic wr_ack;
   scfb_pkg::cfg_type cfg;

   logic                q_full;
   logic                q_push;
   scfb_pkg::entry_type q_push_entry;
   logic                q_pop;
   logic                q_head_valid;
   scfb_pkg::entry_type q_head_entry;

   assign csr_pready = 1'b1;
   assign wr_ack     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg.wr     = wr_ack && (csr_paddr[2] == scfb_pkg::REG_FRAME_MODE);
   assign cfg.mode   = csr_pwdata[0];
   assign mode_in    = cfg.wr ? csr_pwdata[0] : mode_ff;
   assign csr_prdata = (csr_paddr[2] == scfb_pkg::REG_FRAME_MODE) ? {31'h0, mode_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= scfb_pkg::MODE_MODBUS;
      else       mode_ff <= mode_in;
   end

   scfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   scfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   scfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hw/rtl/scfb_front.sv
module scfb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  scfb_pkg::cfg_type     cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // payload_byte
   input  logic                  req_tlast,   // payload_last
   input  logic                  q_full,
   output logic                  q_push,
   output scfb_pkg::entry_type   q_entry
);

   logic        mode_ff, mode_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_ff, held_in;

   logic        accept;
   logic [15:0] init_crc;
   logic [15:0] base_crc;
   logic [15:0] next_crc;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign init_crc   = (mode_ff == scfb_pkg::MODE_FRAMED) ? scfb_pkg::XMODEM_INIT
                                                          : scfb_pkg::MODBUS_INIT;
   assign base_crc   = (pos_ff == scfb_pkg::POS_FIRST) ? init_crc : crc_ff;
   assign next_crc   = (mode_ff == scfb_pkg::MODE_FRAMED)
                       ? scfb_pkg::xmodem_update(base_crc, req_tdata)
                       : scfb_pkg::modbus_update(base_crc, req_tdata);

   always_comb begin
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      crc_in          = crc_ff;
      held_in         = held_ff;
      q_push          = 1'b0;
      q_entry.mode    = mode_ff;
      q_entry.second  = (pos_ff == scfb_pkg::POS_SECOND);
      q_entry.err     = 1'b0;
      q_entry.last    = req_tlast;
      q_entry.data    = req_tdata;
      q_entry.held    = held_ff;
      q_entry.crc     = next_crc;
      if (cfg.wr) begin
         // mode change drops any partial frame
         mode_in = cfg.mode;
         pos_in  = scfb_pkg::POS_FIRST;
         crc_in  = (cfg.mode == scfb_pkg::MODE_FRAMED) ? scfb_pkg::XMODEM_INIT
                                                       : scfb_pkg::MODBUS_INIT;
         held_in = 8'h00;
      end else if (accept) begin
         if (mode_ff == scfb_pkg::MODE_FRAMED && pos_ff == scfb_pkg::POS_FIRST) begin
            if (req_tlast) begin
               // too short for a framed payload
               q_push      = 1'b1;
               q_entry.err = 1'b1;
               held_in     = 8'h00;
               crc_in      = init_crc;
            end else begin
               held_in = req_tdata;
               crc_in  = next_crc;
               pos_in  = scfb_pkg::POS_SECOND;
            end
         end else begin
            q_push = 1'b1;
            crc_in = next_crc;
            pos_in = req_tlast ? scfb_pkg::POS_FIRST : scfb_pkg::POS_LATER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= scfb_pkg::MODE_MODBUS;
         pos_ff  <= scfb_pkg::POS_FIRST;
         crc_ff  <= scfb_pkg::MODBUS_INIT;
         held_ff <= 8'h00;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         held_ff <= held_in;
      end
   end

endmodule

FILE: hw/rtl/scfb_queue.sv
module scfb_queue #(
   parameter int unsigned DEPTH = scfb_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  scfb_pkg::entry_type   push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output scfb_pkg::entry_type   head_entry
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   scfb_pkg::entry_type slot_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

FILE: hw/rtl/scfb_back.sv
module scfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  scfb_pkg::entry_type   head_entry,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte
   output logic                  rsp_tlast,   // out_last
   output logic                  rsp_tuser    // frame_error
);

   // framed sequence: six prefix bytes, held byte, byte, crc hi, crc lo, flag
   localparam logic [3:0] FP_HELD   = 4'd6;
   localparam logic [3:0] FP_DATA   = 4'd7;
   localparam logic [3:0] FP_CRC_HI = 4'd8;
   localparam logic [3:0] FP_CRC_LO = 4'd9;
   localparam logic [3:0] FP_FLAG   = 4'd10;
   // modbus sequence: byte, crc lo, crc hi
   localparam logic [3:0] MP_DATA   = 4'd0;
   localparam logic [3:0] MP_CRC_LO = 4'd1;
   localparam logic [3:0] MP_CRC_HI = 4'd2;

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   logic       load;
   logic [3:0] start_step;
   logic [3:0] end_step;
   logic [3:0] step;
   logic [7:0] sel_byte;

   assign load = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      if (head_entry.err) begin
         start_step = MP_DATA;
         end_step   = MP_DATA;
      end else if (head_entry.mode == scfb_pkg::MODE_FRAMED) begin
         start_step = head_entry.second ? 4'd0 : FP_DATA;
         end_step   = head_entry.last ? FP_FLAG : FP_DATA;
      end else begin
         start_step = MP_DATA;
         end_step   = head_entry.last ? MP_CRC_HI : MP_DATA;
      end
   end

   assign step = busy_ff ? step_ff : start_step;

   always_comb begin
      sel_byte = head_entry.data;
      if (head_entry.err) begin
         sel_byte = 8'h00;
      end else if (head_entry.mode == scfb_pkg::MODE_FRAMED) begin
         case (step)
            4'd0, 4'd2, 4'd4: sel_byte = scfb_pkg::PREFIX_A;
            4'd1, 4'd3, 4'd5: sel_byte = scfb_pkg::PREFIX_B;
            FP_HELD:          sel_byte = head_entry.held;
            FP_DATA:          sel_byte = head_entry.data;
            FP_CRC_HI:        sel_byte = head_entry.crc[15:8];
            FP_CRC_LO:        sel_byte = head_entry.crc[7:0];
            FP_FLAG:          sel_byte = scfb_pkg::END_FLAG;
            default:          sel_byte = head_entry.data;
         endcase
      end else begin
         case (step)
            MP_DATA:   sel_byte = head_entry.data;
            MP_CRC_LO: sel_byte = head_entry.crc[7:0];
            MP_CRC_HI: sel_byte = head_entry.crc[15:8];
            default:   sel_byte = head_entry.data;
         endcase
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      pop      = 1'b0;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = sel_byte;
         err_in   = head_entry.err;
         last_in  = (step == end_step) && (head_entry.last || head_entry.err);
         if (step == end_step) begin
            pop     = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            step_in = step + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule
